[design/elet_pkg.sv]
`timescale 1ns / 1ps
// Package for the event log edge throttle: sizes, codes, item structs and
// the small helper functions used by the rule scanner and the top level.
// No dependencies.
package elet_pkg;

   localparam int RULE_SLOTS = 64;
   localparam int FAMILIES   = 4;
   localparam int SLOT_W     = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int FAM_W      = (FAMILIES > 1) ? $clog2(FAMILIES) : 1;

   localparam logic [14:0] REPORT_MAX = 15'h7fff;

   typedef enum logic [1:0] {
      FUNC_EVENT  = 2'd0,
      FUNC_RULE   = 2'd1,
      FUNC_REPORT = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CSR_QUIET     = 3'd0,
      CSR_FATAL     = 3'd1,
      CSR_WARN      = 3'd2,
      CSR_HEARTBEAT = 3'd3,
      CSR_REPORT    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_RESULT
   } state_type;

   // rule slot contents apart from the valid bit
   typedef struct packed {
      logic [11:0] code;
      logic        routed;
      logic [1:0]  group;
      logic        fault;
      logic        pre;
   } rule_body_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] idx;
      logic              valid;
      rule_body_type     body;
   } rule_wr_type;

   typedef struct packed {
      logic             hit;
      logic             fault;
      logic [FAM_W-1:0] fam;
      logic             pre;
   } scan_result_type;

   // group index modulo FAMILIES, a few conditional subtracts
   function automatic logic [FAM_W-1:0] fam_of(input logic [1:0] g);
      int v;
      v = int'(g);
      for (int k = 0; k < 4; k++) begin
         if (v >= FAMILIES) v = v - FAMILIES;
      end
      return FAM_W'(v);
   endfunction

   // wrapping elapsed test: difference read as signed, at least the interval
   function automatic logic time_passed(input logic [31:0] now,
                                        input logic [31:0] since,
                                        input logic [30:0] interval);
      logic [31:0] d;
      d = now - since;
      return !d[31] && (d[30:0] >= interval);
   endfunction

endpackage

[design/event_log_edge_throttle.sv]
`timescale 1ns / 1ps
// Event log edge throttle top level: handshakes, registers, family and
// drop-report state, decision sequencer. Depends on elet_pkg, elet_rule_scan.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | tuser func, tdata event/rule fields
//   rsp     | out | rsp_tvalid/rsp_tready | tdata persist, report_count
//   csr     | in  | csr_we                | csr_addr, csr_wdata
//
// One item at a time. A non-fatal event reads every rule slot through the
// single memory read port before its result is ready. Fatal events, rule
// writes, reports and clears skip the scan and go straight to the result.
// Reset is synchronous; the rule table comes out of reset all invalid.
// A held result stalls the sequencer; req_tready is low until it moves on.
module event_log_edge_throttle
   import elet_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // code[11:0] level[14:12] now_ms[46:15]
                                   // rule_index[52:47] rule_valid[53]
                                   // rule_routed[54] rule_group[56:55]
                                   // rule_fault[57] rule_preamble[58] zeros
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // persist[0] report_count[15:1]
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [30:0] csr_wdata
);

   // input fields
   logic [11:0] in_code;
   logic [2:0]  in_level;
   logic [31:0] in_now;
   logic [5:0]  in_index;
   func_type    in_func;

   assign in_code  = req_tdata[11:0];
   assign in_level = req_tdata[14:12];
   assign in_now   = req_tdata[46:15];
   assign in_index = req_tdata[52:47];
   assign in_func  = func_type'(req_tuser);

   // registers
   logic        quiet_ff;
   logic [2:0]  fatal_ff;
   logic [2:0]  warn_ff;
   logic [30:0] hb_ff;
   logic [30:0] rpt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         quiet_ff <= 1'b0;
         fatal_ff <= 3'd4;
         warn_ff  <= 3'd2;
         hb_ff    <= 31'd3600000;
         rpt_ff   <= 31'd3600000;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_QUIET:     quiet_ff <= csr_wdata[0];
            CSR_FATAL:     fatal_ff <= csr_wdata[2:0];
            CSR_WARN:      warn_ff  <= csr_wdata[2:0];
            CSR_HEARTBEAT: hb_ff    <= csr_wdata;
            CSR_REPORT:    rpt_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer and state
   state_type   state_ff, state_in;
   logic [11:0] code_ff;
   logic [2:0]  level_ff;
   logic [31:0] now_ff;

   logic              seen_ff   [FAMILIES];
   logic              faulty_ff [FAMILIES];
   logic [31:0]       last_ff   [FAMILIES];
   logic [31:0]       count_ff;
   logic [31:0]       win_ff;
   logic              armed_ff;

   logic              res_persist_ff, res_persist_in;
   logic [14:0]       res_count_ff,   res_count_in;
   logic              rsp_valid_ff;
   logic [15:0]       rsp_data_ff;

   logic              accept, slot_free;
   logic              do_scan, do_report, do_clear, do_decide, do_emit;
   rule_wr_type       wr;
   logic              scan_done;
   scan_result_type   scan;

   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !reset;

   always_comb begin
      wr.en    = accept && (in_func == FUNC_RULE) && (int'(in_index) < RULE_SLOTS);
      wr.idx   = SLOT_W'(in_index);
      wr.valid = req_tdata[53];
      wr.body  = '{code: in_code, routed: req_tdata[54], group: req_tdata[56:55],
                   fault: req_tdata[57], pre: req_tdata[58]};
   end

   elet_rule_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .start  (do_scan),
      .code   (code_ff),
      .done   (scan_done),
      .result (scan)
   );

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      do_scan   = 1'b0;
      do_report = 1'b0;
      do_clear  = 1'b0;
      do_decide = 1'b0;
      do_emit   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RESULT;
               unique case (in_func)
                  FUNC_EVENT: begin
                     if (in_level < fatal_ff) begin
                        do_scan  = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_RULE:   ;
                  FUNC_REPORT: do_report = 1'b1;
                  FUNC_CLEAR:  do_clear  = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            do_decide = 1'b1;
            state_in  = ST_RESULT;
         end
         ST_RESULT: begin
            if (slot_free) begin
               do_emit  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // report release, evaluated on the accepted item
   logic report_rel;
   assign report_rel = armed_ff && (count_ff != '0) && time_passed(in_now, win_ff, rpt_ff);

   // event decision for the latched item
   logic             f_faulty, f_seen, hb_ok;
   logic             d_persist, d_drop, d_upd, d_set_faulty, d_clr_faulty, d_set_seen;
   logic [FAM_W-1:0] fam;

   assign fam      = scan.fam;
   assign f_faulty = faulty_ff[fam];
   assign f_seen   = seen_ff[fam];
   assign hb_ok    = time_passed(now_ff, last_ff[fam], hb_ff);

   always_comb begin
      d_persist    = 1'b0;
      d_drop       = 1'b0;
      d_upd        = 1'b0;
      d_set_faulty = 1'b0;
      d_clr_faulty = 1'b0;
      d_set_seen   = 1'b0;
      priority if (scan.hit && scan.fault) begin
         if (!f_faulty) begin
            d_persist    = 1'b1;
            d_set_faulty = 1'b1;
            d_upd        = 1'b1;
         end else if (hb_ok) begin
            d_persist = 1'b1;
            d_upd     = 1'b1;
         end else begin
            d_drop = 1'b1;
         end
      end else if (level_ff >= warn_ff) begin
         d_persist = 1'b1;
      end else if (quiet_ff && scan.pre) begin
         d_drop = 1'b1;
      end else if (!scan.hit) begin
         d_persist = 1'b1;
      end else if (!f_seen || f_faulty) begin
         d_persist    = 1'b1;
         d_set_seen   = 1'b1;
         d_clr_faulty = 1'b1;
         d_upd        = 1'b1;
      end else if (hb_ok) begin
         d_persist = 1'b1;
         d_upd     = 1'b1;
      end else begin
         d_drop = 1'b1;
      end
   end

   always_comb begin
      res_persist_in = res_persist_ff;
      res_count_in   = res_count_ff;
      if (accept) begin
         res_persist_in = (in_func == FUNC_EVENT);  // fatal; scanned events overwrite
         res_count_in   = '0;
         if (do_report && report_rel) begin
            res_count_in = (count_ff > 32'(REPORT_MAX)) ? REPORT_MAX : count_ff[14:0];
         end
      end else if (do_decide) begin
         res_persist_in = d_persist;
      end
   end

   always_ff @(posedge clock) begin
      res_persist_ff <= res_persist_in;
      res_count_ff   <= res_count_in;
      if (accept) begin
         code_ff  <= in_code;
         level_ff <= in_level;
         now_ff   <= in_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || do_clear) begin
         for (int f = 0; f < FAMILIES; f++) begin
            seen_ff[f]   <= 1'b0;
            faulty_ff[f] <= 1'b0;
            last_ff[f]   <= '0;
         end
         count_ff <= '0;
         win_ff   <= '0;
         armed_ff <= 1'b0;
      end else if (do_report) begin
         if (report_rel) begin
            count_ff <= '0;
            armed_ff <= 1'b0;
         end
      end else if (do_decide) begin
         if (d_set_faulty) faulty_ff[fam] <= 1'b1;
         if (d_clr_faulty) faulty_ff[fam] <= 1'b0;
         if (d_set_seen)   seen_ff[fam]   <= 1'b1;
         if (d_upd)        last_ff[fam]   <= now_ff;
         if (d_drop) begin
            if (count_ff == '0) begin
               win_ff   <= now_ff;
               armed_ff <= 1'b1;
            end
            if (count_ff != '1) count_ff <= count_ff + 32'd1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_emit) rsp_data_ff <= {res_count_ff, res_persist_ff};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[design/elet_rule_scan.sv]
`timescale 1ns / 1ps
// Rule table: a one-port-read synchronous memory of rule slots plus valid
// flops, and the sequential scan that finds the family rule of a code.
// Depends on elet_pkg.
module elet_rule_scan
   import elet_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  rule_wr_type     wr,
   input  logic            start,
   input  logic [11:0]     code,
   output logic            done,
   output scan_result_type result
);

   rule_body_type     mem [RULE_SLOTS];
   logic [RULE_SLOTS-1:0] valid_ff;

   logic              running_ff;
   logic [SLOT_W-1:0] addr_ff;
   logic              rd_pend_ff;
   logic              rd_last_ff;
   logic              rd_valid_ff;
   rule_body_type     rd_body_ff;
   logic              done_ff;
   scan_result_type   acc_ff;
   logic              match;

   always_ff @(posedge clock) begin
      if (wr.en) mem[wr.idx] <= wr.body;
      rd_body_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.idx] <= wr.valid;
      end
   end

   // read issue side: one slot per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         addr_ff    <= '0;
         rd_pend_ff <= 1'b0;
         rd_last_ff <= 1'b0;
      end else begin
         rd_pend_ff <= running_ff;
         rd_last_ff <= running_ff && (addr_ff == SLOT_W'(RULE_SLOTS - 1));
         if (start) begin
            running_ff <= 1'b1;
            addr_ff    <= '0;
         end else if (running_ff) begin
            if (addr_ff == SLOT_W'(RULE_SLOTS - 1)) running_ff <= 1'b0;
            else addr_ff <= addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[addr_ff];
   end

   assign match = rd_pend_ff && rd_valid_ff && (rd_body_ff.code == code);

   // data side: first routed match wins, preamble is an OR over all matches
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
         acc_ff  <= '0;
      end else begin
         done_ff <= rd_pend_ff && rd_last_ff;
         if (start) begin
            acc_ff <= '0;
         end else if (match) begin
            if (rd_body_ff.pre) acc_ff.pre <= 1'b1;
            if (rd_body_ff.routed && !acc_ff.hit) begin
               acc_ff.hit   <= 1'b1;
               acc_ff.fault <= rd_body_ff.fault;
               acc_ff.fam   <= fam_of(rd_body_ff.group);
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

[test/tb_event_log_edge_throttle.sv]
`timescale 1ns / 1ps
// Testbench for event_log_edge_throttle: a directed table followed by random
// phases under several register settings, checked against an in-bench model.
// Depends on elet_pkg and the design sources.
module tb_event_log_edge_throttle;
   import elet_pkg::*;

   localparam int STALL_LIMIT = 5000;

   typedef struct packed {
      func_type    func;
      logic [11:0] code;
      logic [2:0]  level;
      logic [31:0] now_ms;
      logic [5:0]  slot;
      logic        valid;
      logic        routed;
      logic [1:0]  group;
      logic        fault;
      logic        pre;
   } log_item_type;

   typedef struct packed {
      logic        persist;
      logic [14:0] report_count;
   } verdict_type;

   typedef struct {
      log_item_type item;
      bit           typed;
      verdict_type  want;
   } script_row_type;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [63:0]   req_tdata  = '0;
   logic [1:0]    req_tuser  = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [15:0]   rsp_tdata;
   logic          csr_we     = 1'b0;
   csr_index_type csr_addr   = CSR_QUIET;
   logic [30:0]   csr_wdata  = '0;

   // decision model state
   logic          slot_on   [RULE_SLOTS];
   rule_body_type slot_rule [RULE_SLOTS];
   logic          fam_seen   [FAMILIES];
   logic          fam_faulty [FAMILIES];
   logic [31:0]   fam_last   [FAMILIES];
   logic [31:0]   drop_count;
   logic [31:0]   window_start;
   logic          window_armed;
   logic          cfg_quiet;
   logic [2:0]    cfg_fatal;
   logic [2:0]    cfg_warn;
   logic [30:0]   cfg_heartbeat;
   logic [30:0]   cfg_report;

   verdict_type     verdict_q [$];
   script_row_type  script_q [$];
   verdict_type     due;
   logic [11:0]   code_pool [8];
   logic [31:0]   clock_ms;

   int mismatches = 0;
   int n_items    = 0;
   int n_results  = 0;
   int n_kept     = 0;
   int n_dropped  = 0;
   int n_reports  = 0;
   int calm_left  = 0;
   int hold_left  = 0;
   int steady_left = 0;
   int rsp_roll;
   int quiet_cycles = 0;
   bit long_hold_done = 1'b0;

   event_log_edge_throttle u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   // signed-difference elapsed test on the wrapping millisecond base
   function automatic logic interval_due(input logic [31:0] now, input logic [31:0] since,
                                         input logic [30:0] ival);
      logic [31:0] d;
      d = now - since;
      return (d[31] == 1'b0) && (d[30:0] >= ival);
   endfunction

   function automatic void forget_families();
      for (int f = 0; f < FAMILIES; f++) begin
         fam_seen[f]   = 1'b0;
         fam_faulty[f] = 1'b0;
         fam_last[f]   = '0;
      end
      drop_count   = '0;
      window_start = '0;
      window_armed = 1'b0;
   endfunction

   function automatic void count_drop(input logic [31:0] now);
      if (drop_count == 0) begin
         window_start = now;
         window_armed = 1'b1;
      end
      if (drop_count != 32'hffff_ffff) drop_count = drop_count + 1;
      n_dropped++;
   endfunction

   function automatic verdict_type judge_item(input log_item_type it);
      verdict_type v;
      logic     hit;
      logic     pre;
      logic     flt;
      int       fam;
      v   = '0;
      hit = 1'b0;
      pre = 1'b0;
      flt = 1'b0;
      fam = 0;
      case (it.func)
         FUNC_EVENT: begin
            if (it.level >= cfg_fatal) begin
               v.persist = 1'b1;
            end else begin
               // first routed match picks the family; preamble is any match
               for (int i = 0; i < RULE_SLOTS; i++) begin
                  if (slot_on[i] && slot_rule[i].code == it.code) begin
                     if (slot_rule[i].pre) pre = 1'b1;
                     if (!hit && slot_rule[i].routed) begin
                        hit = 1'b1;
                        flt = slot_rule[i].fault;
                        fam = int'(slot_rule[i].group) % FAMILIES;
                     end
                  end
               end
               if (hit && flt) begin
                  if (!fam_faulty[fam]) begin
                     fam_faulty[fam] = 1'b1;
                     fam_last[fam]   = it.now_ms;
                     v.persist       = 1'b1;
                  end else if (interval_due(it.now_ms, fam_last[fam], cfg_heartbeat)) begin
                     fam_last[fam] = it.now_ms;
                     v.persist     = 1'b1;
                  end else begin
                     count_drop(it.now_ms);
                  end
               end else if (it.level >= cfg_warn) begin
                  v.persist = 1'b1;
               end else if (cfg_quiet && pre) begin
                  count_drop(it.now_ms);
               end else if (!hit) begin
                  v.persist = 1'b1;
               end else if (!fam_seen[fam] || fam_faulty[fam]) begin
                  fam_seen[fam]   = 1'b1;
                  fam_faulty[fam] = 1'b0;
                  fam_last[fam]   = it.now_ms;
                  v.persist       = 1'b1;
               end else if (interval_due(it.now_ms, fam_last[fam], cfg_heartbeat)) begin
                  fam_last[fam] = it.now_ms;
                  v.persist     = 1'b1;
               end else begin
                  count_drop(it.now_ms);
               end
            end
         end
         FUNC_RULE: begin
            if (int'(it.slot) < RULE_SLOTS) begin
               slot_on[it.slot]   = it.valid;
               slot_rule[it.slot] = {it.code, it.routed, it.group, it.fault, it.pre};
            end
         end
         FUNC_REPORT: begin
            if (window_armed && drop_count != 0 &&
                interval_due(it.now_ms, window_start, cfg_report)) begin
               v.report_count = (drop_count > 32'd32767) ? REPORT_MAX : drop_count[14:0];
               drop_count     = '0;
               window_armed   = 1'b0;
            end
         end
         default: begin
            forget_families();
         end
      endcase
      return v;
   endfunction

   // ------------------------------------------------------------- stimulus

   task automatic offer(input log_item_type it, input bit typed, input verdict_type want);
      verdict_type v;
      int       gap;
      int       r;
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            calm_left = 40;
            gap = 0;
         end else if (r < 55) begin
            gap = 0;
         end else if (r < 88) begin
            gap = $urandom_range(1, 3);
         end else if (r < 97) begin
            gap = $urandom_range(4, 15);
         end else begin
            gap = $urandom_range(20, 60);
         end
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.func;
      req_tdata  <= {5'b0, it.pre, it.fault, it.group, it.routed, it.valid, it.slot,
                     it.now_ms, it.level, it.code};
      do @(posedge clock); while (!req_tready);
      v = judge_item(it);
      if (it.func == FUNC_EVENT && v.persist) n_kept++;
      if (v.report_count != 0) n_reports++;
      verdict_q.push_back(typed ? want : v);
      n_items++;
   endtask

   // flags: {valid, routed, group[1:0], fault, pre}; want_persist < 0 leaves
   // the row to the model
   task automatic add_row(input func_type f, input logic [11:0] code, input logic [2:0] lvl,
                          input logic [31:0] now, input logic [5:0] slot,
                          input logic [5:0] flags, input int want_persist,
                          input int want_count);
      script_row_type e;
      e.item        = '0;
      e.item.func   = f;
      e.item.code   = code;
      e.item.level  = lvl;
      e.item.now_ms = now;
      e.item.slot   = slot;
      {e.item.valid, e.item.routed, e.item.group, e.item.fault, e.item.pre} = flags;
      e.typed             = (want_persist >= 0);
      e.want.persist      = want_persist[0];
      e.want.report_count = want_count[14:0];
      script_q.push_back(e);
   endtask

   task automatic put_reg(input csr_index_type idx, input logic [30:0] val);
      csr_addr  <= idx;
      csr_wdata <= val;
      csr_we    <= 1'b1;
      @(posedge clock);
   endtask

   task automatic write_settings(input logic q, input logic [2:0] fl, input logic [2:0] wl,
                                 input logic [30:0] hb, input logic [30:0] rp);
      put_reg(CSR_QUIET, 31'(q));
      put_reg(CSR_FATAL, 31'(fl));
      put_reg(CSR_WARN, 31'(wl));
      put_reg(CSR_HEARTBEAT, hb);
      put_reg(CSR_REPORT, rp);
      csr_we        <= 1'b0;
      cfg_quiet     = q;
      cfg_fatal     = fl;
      cfg_warn      = wl;
      cfg_heartbeat = hb;
      cfg_report    = rp;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input int n);
      log_item_type it;
      verdict_type  none;
      int          r;
      int          roll;
      logic [31:0] span;
      none = '0;
      for (int k = 0; k < n; k++) begin
         it   = '0;
         r    = $urandom_range(0, 99);
         span = $urandom_range(0, 1) ? {1'b0, cfg_heartbeat} : {1'b0, cfg_report};
         if (span == 0) span = 32'd40;
         // mostly inside one interval, some past it, a few backwards or anywhere
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            clock_ms = clock_ms + $urandom_range(0, span / 4);
         end else if (roll < 85) begin
            clock_ms = clock_ms + $urandom_range(span / 2, span + span / 4);
         end else if (roll < 95) begin
            clock_ms = clock_ms - $urandom_range(0, span);
         end else begin
            clock_ms = $urandom;
         end
         it.now_ms = clock_ms;
         it.code   = ($urandom_range(0, 99) < 85) ? code_pool[$urandom_range(0, 7)]
                                                  : 12'($urandom);
         if (cfg_warn > 0 && $urandom_range(0, 99) < 60) begin
            it.level = 3'($urandom_range(0, cfg_warn - 1));
         end else begin
            it.level = 3'($urandom_range(0, 7));
         end
         it.slot   = 6'($urandom_range(0, 63));
         it.valid  = ($urandom_range(0, 99) < 85);
         it.routed = ($urandom_range(0, 99) < 70);
         it.group  = 2'($urandom_range(0, 3));
         it.fault  = ($urandom_range(0, 99) < 40);
         it.pre    = ($urandom_range(0, 99) < 40);
         // each phase opens with a burst of rule writes so events find rules
         if (k < 12 || r < 15) begin
            it.func = FUNC_RULE;
         end else if (r < 25) begin
            it.func = FUNC_REPORT;
         end else if (r < 27) begin
            it.func = FUNC_CLEAR;
         end else begin
            it.func = FUNC_EVENT;
         end
         offer(it, 1'b0, none);
      end
   endtask

   // ------------------------------------------------------ result side

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= (hold_left == 1);
      end else if (!long_hold_done && n_results >= 400) begin
         // long hold-off: the block fills up and stalls its input
         long_hold_done <= 1'b1;
         hold_left      <= 700;
         rsp_tready     <= 1'b0;
      end else if (steady_left > 0) begin
         steady_left <= steady_left - 1;
         rsp_tready  <= 1'b1;
      end else begin
         rsp_roll = $urandom_range(0, 99);
         if (rsp_roll < 2) begin
            steady_left <= 50;
            rsp_tready  <= 1'b1;
         end else if (rsp_roll < 65) begin
            rsp_tready <= 1'b1;
         end else if (rsp_roll < 92) begin
            rsp_tready <= 1'b0;
            hold_left  <= $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b0;
            hold_left  <= $urandom_range(10, 60);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results <= n_results + 1;
         if (verdict_q.size() == 0) begin
            $error("result item with nothing expected: tdata %h", rsp_tdata);
            mismatches++;
         end else begin
            due = verdict_q.pop_front();
            if (rsp_tdata[0] !== due.persist) begin
               $error("persist: expected %0d, got %0d", due.persist, rsp_tdata[0]);
               mismatches++;
            end
            if (rsp_tdata[15:1] !== due.report_count) begin
               $error("report_count: expected %0d, got %0d", due.report_count,
                      rsp_tdata[15:1]);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------ sequence

   initial begin
      logic        q;
      logic [2:0]  fl;
      logic [2:0]  wl;
      logic [30:0] hb;
      logic [30:0] rp;
      int          n;
      for (int i = 0; i < RULE_SLOTS; i++) begin
         slot_on[i]   = 1'b0;
         slot_rule[i] = '0;
      end
      forget_families();
      cfg_quiet     = 1'b0;
      cfg_fatal     = 3'd4;
      cfg_warn      = 3'd2;
      cfg_heartbeat = 31'd3600000;
      cfg_report    = 31'd3600000;
      clock_ms      = $urandom;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: no rules, top level fatal, empty report
      add_row(FUNC_EVENT,  12'h000, 3'd0, 32'd0,         6'd0,  6'b0_0_00_0_0, 1, 0);
      add_row(FUNC_EVENT,  12'hfff, 3'd7, 32'hffff_ffff, 6'd63, 6'b1_1_11_1_1, 1, 0);
      add_row(FUNC_REPORT, 12'h000, 3'd0, 32'd0,         6'd0,  6'b0_0_00_0_0, 0, 0);
      // routine family 1, fault family 1 with preamble, unrouted fault-flagged
      // preamble code, family 3 on the top code, a slot shadowed by slot 0
      add_row(FUNC_RULE,   12'h010, 3'd0, 32'd0,         6'd0,  6'b1_1_01_0_0, 0, 0);
      add_row(FUNC_RULE,   12'h011, 3'd7, 32'hffff_ffff, 6'd63, 6'b1_1_01_1_1, 0, 0);
      add_row(FUNC_RULE,   12'h020, 3'd0, 32'd0,         6'd5,  6'b1_0_11_1_1, 0, 0);
      add_row(FUNC_RULE,   12'hfff, 3'd0, 32'd0,         6'd6,  6'b1_1_11_0_0, 0, 0);
      add_row(FUNC_RULE,   12'h010, 3'd0, 32'd0,         6'd7,  6'b1_1_10_1_0, 0, 0);
      // first routine event, then a repeat inside the heartbeat
      add_row(FUNC_EVENT,  12'h010, 3'd0, 32'd1000,      6'd0,  6'b0_0_00_0_0, 1, 0);
      add_row(FUNC_EVENT,  12'h010, 3'd1, 32'd2000,      6'd0,  6'b0_0_00_0_0, 0, 0);
      // failing edge, repeat, heartbeat, recovery, unrouted preamble code
      add_row(FUNC_EVENT,  12'h011, 3'd0, 32'd3000,      6'd0,  6'b0_0_00_0_0, -1, 0);
      add_row(FUNC_EVENT,  12'h011, 3'd3, 32'd4000,      6'd0,  6'b0_0_00_0_0, -1, 0);
      add_row(FUNC_EVENT,  12'h011, 3'd3, 32'd3604000,   6'd0,  6'b0_0_00_0_0, -1, 0);
      add_row(FUNC_EVENT,  12'h010, 3'd0, 32'd3605000,   6'd0,  6'b0_0_00_0_0, -1, 0);
      add_row(FUNC_EVENT,  12'h020, 3'd1, 32'd3606000,   6'd0,  6'b0_0_00_0_0, -1, 0);
      // report too early, then due with two drops, then empty
      add_row(FUNC_REPORT, 12'h000, 3'd0, 32'd3000,      6'd0,  6'b0_0_00_0_0, -1, 0);
      add_row(FUNC_REPORT, 12'h000, 3'd0, 32'd3602000,   6'd0,  6'b0_0_00_0_0, 0, 2);
      add_row(FUNC_REPORT, 12'h000, 3'd0, 32'd3602001,   6'd0,  6'b0_0_00_0_0, 0, 0);
      // family 3 across the signed midpoint and the wrap of the time base
      add_row(FUNC_EVENT,  12'hfff, 3'd1, 32'h7fff_0000, 6'd0,  6'b0_0_00_0_0, -1, 0);
      add_row(FUNC_EVENT,  12'hfff, 3'd0, 32'hffff_8000, 6'd0,  6'b0_0_00_0_0, -1, 0);
      add_row(FUNC_EVENT,  12'hfff, 3'd0, 32'h8035_ee80, 6'd0,  6'b0_0_00_0_0, -1, 0);
      add_row(FUNC_REPORT, 12'h000, 3'd0, 32'h0037_0000, 6'd0,  6'b0_0_00_0_0, -1, 0);
      // clear keeps the rules, forgets the families
      add_row(FUNC_CLEAR,  12'h000, 3'd0, 32'd0,         6'd0,  6'b0_0_00_0_0, 0, 0);
      add_row(FUNC_EVENT,  12'h010, 3'd1, 32'd5,         6'd0,  6'b0_0_00_0_0, -1, 0);
      add_row(FUNC_EVENT,  12'h000, 3'd3, 32'd6,         6'd0,  6'b0_0_00_0_0, -1, 0);

      foreach (script_q[k]) offer(script_q[k].item, script_q[k].typed, script_q[k].want);
      settle();

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin q = 1'b0; fl = 3'd4; wl = 3'd2; hb = 31'd1000; rp = 31'd5000; n = 220; end
            1: begin q = 1'b1; fl = 3'd7; wl = 3'd7; hb = 31'd0; rp = 31'd0; n = 200; end
            2: begin
               q = 1'b1; fl = 3'd7; wl = 3'd3; hb = 31'h7fff_ffff; rp = 31'h7fff_ffff;
               n = 200;
            end
            3: begin q = 1'b0; fl = 3'd0; wl = 3'd0; hb = 31'd200; rp = 31'd200; n = 60; end
            6: begin q = 1'b1; fl = 3'd5; wl = 3'd1; hb = 31'd50; rp = 31'd300; n = 180; end
            default: begin
               q  = 1'($urandom_range(0, 1));
               fl = $urandom_range(0, 99) < 80 ? 3'($urandom_range(3, 7))
                                               : 3'($urandom_range(0, 7));
               wl = 3'($urandom_range(0, 7));
               hb = 31'($urandom_range(0, 4000));
               rp = 31'($urandom_range(0, 20000));
               n  = 200;
            end
         endcase
         foreach (code_pool[c]) code_pool[c] = 12'($urandom);
         write_settings(q, fl, wl, hb, rp);
         run_phase(n);
         settle();
      end

      repeat (80) @(posedge clock);
      $display("Covered %0d items (%0d from the directed table) over 8 register settings.",
               n_items, script_q.size());
      $display("Events kept %0d, dropped %0d; %0d reports released; %0d mismatches.",
               n_kept, n_dropped, n_reports, mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
